// ----- hdl/nanc_pkg.sv -----
// Package for the NLMS noise canceller: sequencer states, register codes and fixed formats.
package nanc_pkg;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDOLD,
    ST_PWSUB,
    ST_PWADD,
    ST_PWFIN,
    ST_FIR,
    ST_ERR,
    ST_NUM,
    ST_DIVINIT,
    ST_DIV,
    ST_GSET,
    ST_UPD,
    ST_GAIN,
    ST_RES,
    ST_CORR,
    ST_CFIN,
    ST_OUT
  } state_t;

  localparam logic [2:0] REG_ENABLE  = 3'd0;
  localparam logic [2:0] REG_MODE    = 3'd1;
  localparam logic [2:0] REG_GAIN    = 3'd2;
  localparam logic [2:0] REG_FF_STEP = 3'd3;
  localparam logic [2:0] REG_FB_STEP = 3'd4;

  localparam logic [2:0] MODE_FB_A = 3'd2;
  localparam logic [2:0] MODE_FB_B = 3'd3;

  localparam logic               RST_ENABLE  = 1'b1;
  localparam logic [2:0]         RST_MODE    = 3'd2;
  localparam logic signed [15:0] RST_GAIN    = 16'sd4096;
  localparam logic [19:0]        RST_FF_STEP = 20'd16777;
  localparam logic [19:0]        RST_FB_STEP = 20'd8389;

  localparam int INT_BITS  = 24;  // internal sample format Q1.23
  localparam int RES_BITS  = 26;  // residual format Q3.23
  localparam int W_BITS    = 32;  // weights Q2.30
  localparam int PROD_BITS = 60;  // shared multiplier output
  localparam int WIDE_BITS = 66;  // scratch width for rounding and saturation
  localparam int NUM_BITS  = 52;  // step times error magnitude
  localparam int DIV_BITS  = 81;  // numerator scaled by 2^29
  localparam int G_BITS    = 39;  // adaptation gain, sign and 38 magnitude bits

  localparam logic [G_BITS-1:0]  GAIN_LIMIT = 39'h20_0000_0000;
  localparam logic [26:0]        POWER_EPS  = 27'd70368744;
  localparam logic signed [26:0] CORR_GAIN  = 27'sd19661;

endpackage

// ----- hdl/nlms_active_noise_canceller.sv -----
// Top level of the NLMS noise canceller: sequencer, shared multiplier, divider and tap memories.
// The feedback filter runs after the feedforward one only in the feedback modes; a disabled
// block passes the feedback sample through. The single shared multiplier sets the rate: one
// tap per cycle in the FIR pass, the high and low gain halves of each tap in turn in the weight
// update, and the gain divider retires one quotient bit per cycle. After reset a clearing pass
// zeroes the tap memories while no request is accepted.
module nlms_active_noise_canceller #(
  parameter int TAPS        = 512,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] ff_sample,
  input  logic signed [SAMPLE_BITS-1:0] fb_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] speaker_sample,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int PW_W  = 2 * nanc_pkg::RES_BITS + AW;
  localparam int REM_W = PW_W + 1;
  localparam int CW0   = $clog2(2 * TAPS + 2) + 1;
  localparam int CW    = (CW0 > 8) ? CW0 : 8;
  localparam int WB    = nanc_pkg::WIDE_BITS;

  typedef logic signed [WB-1:0] wide_t;

  function automatic wide_t rnd(input wide_t v, input int k);
    wide_t half;
    half = wide_t'(1) <<< (k - 1);
    return (v + half) >>> k;
  endfunction

  function automatic wide_t sat_w(input wide_t v, input int bits);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (bits - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic signed [nanc_pkg::INT_BITS-1:0] to_int(
      input logic signed [SAMPLE_BITS-1:0] s);
    wide_t v;
    v = wide_t'(s);
    if (SAMPLE_BITS > nanc_pkg::INT_BITS) begin
      v = sat_w(rnd(v, SAMPLE_BITS - nanc_pkg::INT_BITS), nanc_pkg::INT_BITS);
    end else begin
      v = v <<< ((SAMPLE_BITS > nanc_pkg::INT_BITS) ? 0 : nanc_pkg::INT_BITS - SAMPLE_BITS);
    end
    return v[nanc_pkg::INT_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] from_int(
      input logic signed [nanc_pkg::INT_BITS-1:0] s);
    wide_t v;
    v = wide_t'(s);
    if (SAMPLE_BITS < nanc_pkg::INT_BITS) begin
      v = sat_w(rnd(v, nanc_pkg::INT_BITS - SAMPLE_BITS), SAMPLE_BITS);
    end else begin
      v = v <<< ((SAMPLE_BITS < nanc_pkg::INT_BITS) ? 0 : SAMPLE_BITS - nanc_pkg::INT_BITS);
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Configuration registers.
  logic                        anc_enable;
  logic [2:0]                  anc_mode;
  logic signed [15:0]          intensity_gain;
  logic [19:0]                 ff_step_size;
  logic [19:0]                 fb_step_size;
  logic                        cfg_wr;
  logic [2:0]                  cfg_idx;

  nanc_pkg::state_t state, state_next;

  logic [CW-1:0]               cnt;
  logic [CW-2:0]               tap;
  logic                        ph;
  logic [AW-1:0]               jptr;
  logic [AW-1:0]               ff_pos, fb_pos, pos_cur;
  logic [PW_W-1:0]             ff_pw, fb_pw, pw_cur;
  logic                        fsel;
  logic                        pass;
  logic signed [SAMPLE_BITS-1:0] raw_fb;
  logic signed [nanc_pkg::INT_BITS-1:0] tgt;
  logic signed [nanc_pkg::RES_BITS-1:0] ref_x;
  logic signed [nanc_pkg::RES_BITS-1:0] rres;
  logic signed [nanc_pkg::INT_BITS-1:0] o_int;
  logic signed [nanc_pkg::W_BITS-1:0]   y_reg;
  logic [31:0]                 mag;
  logic                        eneg;
  logic signed [nanc_pkg::G_BITS-1:0]   g;
  logic signed [nanc_pkg::RES_BITS-1:0] xl;
  logic signed [nanc_pkg::W_BITS-1:0]   wl;
  logic signed [nanc_pkg::PROD_BITS-1:0] prod, lo_hold, acc, mul_p;
  logic signed [32:0]          mul_a;
  logic signed [26:0]          mul_b;
  logic [nanc_pkg::DIV_BITS-1:0] nreg;
  logic [REM_W-1:0]            rem, r2, den;
  logic                        ge;
  logic [nanc_pkg::G_BITS-1:0] q, qn;
  logic                        ovf;
  logic [19:0]                 step_cur;

  // Tap memories.
  logic signed [nanc_pkg::W_BITS-1:0]   ffw_mem [TAPS];
  logic signed [nanc_pkg::W_BITS-1:0]   fbw_mem [TAPS];
  logic signed [nanc_pkg::INT_BITS-1:0] ffx_mem [TAPS];
  logic signed [nanc_pkg::RES_BITS-1:0] fbx_mem [TAPS];
  logic signed [nanc_pkg::W_BITS-1:0]   ffw_rd, fbw_rd, w_rd;
  logic signed [nanc_pkg::INT_BITS-1:0] ffx_rd;
  logic signed [nanc_pkg::RES_BITS-1:0] fbx_rd, x_rd;
  logic                        we_ffw, we_fbw, we_ffx, we_fbx;
  logic [AW-1:0]               raddr_w, raddr_x, waddr;
  logic signed [nanc_pkg::W_BITS-1:0]   wdata_w;
  logic signed [nanc_pkg::RES_BITS-1:0] wdata_x;

  // Weight update, error, residual and correction datapath.
  wide_t upd_sum, upd_r, wsum;
  wide_t err_y, err_e, err_abs;
  wide_t res_r, cor_r, res_s;

  assign pready   = 1'b1;
  assign in_stall = (state != nanc_pkg::ST_IDLE);
  assign cfg_wr   = psel & penable & pwrite;
  assign cfg_idx  = paddr[4:2];
  assign tap      = cnt[CW-1:1];
  assign ph       = cnt[0];
  assign pos_cur  = fsel ? fb_pos : ff_pos;
  assign pw_cur   = fsel ? fb_pw : ff_pw;
  assign step_cur = fsel ? fb_step_size : ff_step_size;
  assign w_rd     = fsel ? fbw_rd : ffw_rd;
  assign x_rd     = fsel ? fbx_rd : nanc_pkg::RES_BITS'(ffx_rd);
  assign mul_p    = mul_a * mul_b;

  assign den = REM_W'(pw_cur);
  assign r2  = {rem[REM_W-2:0], nreg[nanc_pkg::DIV_BITS-1]};
  assign ge  = (r2 >= den);
  assign qn  = {q[nanc_pkg::G_BITS-2:0], ge};

  always_comb begin
    upd_sum = (wide_t'(prod) <<< 20) + wide_t'(lo_hold);
    upd_r   = rnd(upd_sum, 23);
    wsum    = sat_w(upd_r + wide_t'(wl), nanc_pkg::W_BITS);
    err_y   = sat_w(rnd(wide_t'(acc), 22), nanc_pkg::W_BITS);
    err_e   = sat_w(wide_t'(tgt) - err_y, nanc_pkg::W_BITS);
    err_abs = (err_e < 0) ? -err_e : err_e;
    res_r   = sat_w(wide_t'(tgt) - rnd(wide_t'(prod), 12), nanc_pkg::RES_BITS);
    res_s   = sat_w(res_r, nanc_pkg::INT_BITS);
    cor_r   = sat_w(wide_t'(rres) - rnd(wide_t'(prod), 16), nanc_pkg::INT_BITS);
  end

  always_ff @(posedge clk) begin
    if (we_ffw) ffw_mem[waddr] <= wdata_w;
    ffw_rd <= ffw_mem[raddr_w];
  end

  always_ff @(posedge clk) begin
    if (we_fbw) fbw_mem[waddr] <= wdata_w;
    fbw_rd <= fbw_mem[raddr_w];
  end

  always_ff @(posedge clk) begin
    if (we_ffx) ffx_mem[waddr] <= wdata_x[nanc_pkg::INT_BITS-1:0];
    ffx_rd <= ffx_mem[raddr_x];
  end

  always_ff @(posedge clk) begin
    if (we_fbx) fbx_mem[waddr] <= wdata_x;
    fbx_rd <= fbx_mem[raddr_x];
  end

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      anc_enable     <= nanc_pkg::RST_ENABLE;
      anc_mode       <= nanc_pkg::RST_MODE;
      intensity_gain <= nanc_pkg::RST_GAIN;
      ff_step_size   <= nanc_pkg::RST_FF_STEP;
      fb_step_size   <= nanc_pkg::RST_FB_STEP;
    end else if (cfg_wr) begin
      case (cfg_idx)
        nanc_pkg::REG_ENABLE:  anc_enable     <= pwdata[0];
        nanc_pkg::REG_MODE:    anc_mode       <= pwdata[2:0];
        nanc_pkg::REG_GAIN:    intensity_gain <= pwdata[15:0];
        nanc_pkg::REG_FF_STEP: ff_step_size   <= pwdata[19:0];
        nanc_pkg::REG_FB_STEP: fb_step_size   <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      nanc_pkg::REG_ENABLE:  prdata = {31'd0, anc_enable};
      nanc_pkg::REG_MODE:    prdata = {29'd0, anc_mode};
      nanc_pkg::REG_GAIN:    prdata = {{16{intensity_gain[15]}}, intensity_gain};
      nanc_pkg::REG_FF_STEP: prdata = {12'd0, ff_step_size};
      nanc_pkg::REG_FB_STEP: prdata = {12'd0, fb_step_size};
      default:               prdata = 32'd0;
    endcase
  end

  // Sequencer: next state, memory ports and multiplier operands.
  always_comb begin
    state_next = state;
    raddr_w    = cnt[AW-1:0];
    raddr_x    = jptr;
    waddr      = cnt[AW-1:0];
    wdata_w    = '0;
    wdata_x    = '0;
    we_ffw     = 1'b0;
    we_fbw     = 1'b0;
    we_ffx     = 1'b0;
    we_fbx     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      nanc_pkg::ST_CLEAR: begin
        we_ffw = 1'b1;
        we_fbw = 1'b1;
        we_ffx = 1'b1;
        we_fbx = 1'b1;
        if (cnt == CW'(TAPS - 1)) state_next = nanc_pkg::ST_IDLE;
      end
      nanc_pkg::ST_IDLE: begin
        if (in_valid) state_next = anc_enable ? nanc_pkg::ST_RDOLD : nanc_pkg::ST_OUT;
      end
      nanc_pkg::ST_RDOLD: begin
        raddr_x    = pos_cur;
        state_next = nanc_pkg::ST_PWSUB;
      end
      nanc_pkg::ST_PWSUB: begin
        mul_a      = 33'(x_rd);
        mul_b      = 27'(x_rd);
        state_next = nanc_pkg::ST_PWADD;
      end
      nanc_pkg::ST_PWADD: begin
        mul_a      = 33'(ref_x);
        mul_b      = 27'(ref_x);
        waddr      = pos_cur;
        wdata_x    = ref_x;
        we_ffx     = !fsel;
        we_fbx     = fsel;
        state_next = nanc_pkg::ST_PWFIN;
      end
      nanc_pkg::ST_PWFIN: state_next = nanc_pkg::ST_FIR;
      nanc_pkg::ST_FIR: begin
        mul_a = 33'(w_rd);
        mul_b = 27'(x_rd);
        if (cnt == CW'(TAPS + 1)) state_next = nanc_pkg::ST_ERR;
      end
      nanc_pkg::ST_ERR: state_next = nanc_pkg::ST_NUM;
      nanc_pkg::ST_NUM: begin
        mul_a      = {1'b0, mag};
        mul_b      = {7'd0, step_cur};
        state_next = nanc_pkg::ST_DIVINIT;
      end
      nanc_pkg::ST_DIVINIT: state_next = nanc_pkg::ST_DIV;
      nanc_pkg::ST_DIV: begin
        if (cnt == CW'(nanc_pkg::DIV_BITS - 1)) state_next = nanc_pkg::ST_GSET;
      end
      nanc_pkg::ST_GSET: state_next = nanc_pkg::ST_UPD;
      nanc_pkg::ST_UPD: begin
        // Even cycles fetch a tap and multiply the high gain half of the previous tap;
        // odd cycles multiply the low half and write back the previous tap's weight.
        raddr_w = tap[AW-1:0];
        if (ph) begin
          mul_a = 33'(x_rd);
          mul_b = {7'd0, g[19:0]};
          if (tap != '0) begin
            waddr   = AW'(tap - 1'b1);
            wdata_w = wsum[nanc_pkg::W_BITS-1:0];
            we_ffw  = !fsel;
            we_fbw  = fsel;
          end
        end else begin
          mul_a = 33'(xl);
          mul_b = 27'($signed(g[nanc_pkg::G_BITS-1:20]));
        end
        if (cnt == CW'(2 * TAPS + 1)) begin
          state_next = fsel ? nanc_pkg::ST_CORR : nanc_pkg::ST_GAIN;
        end
      end
      nanc_pkg::ST_GAIN: begin
        mul_a      = 33'(y_reg);
        mul_b      = 27'(intensity_gain);
        state_next = nanc_pkg::ST_RES;
      end
      nanc_pkg::ST_RES: begin
        if (anc_mode == nanc_pkg::MODE_FB_A || anc_mode == nanc_pkg::MODE_FB_B) begin
          state_next = nanc_pkg::ST_RDOLD;
        end else begin
          state_next = nanc_pkg::ST_OUT;
        end
      end
      nanc_pkg::ST_CORR: begin
        mul_a      = 33'(y_reg);
        mul_b      = nanc_pkg::CORR_GAIN;
        state_next = nanc_pkg::ST_CFIN;
      end
      nanc_pkg::ST_CFIN: state_next = nanc_pkg::ST_OUT;
      nanc_pkg::ST_OUT: begin
        if (!out_valid || !out_stall) state_next = nanc_pkg::ST_IDLE;
      end
      default: state_next = nanc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nanc_pkg::ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + 1'b1;
    end
  end

  // Control registers of the filters.
  always_ff @(posedge clk) begin
    if (rst) begin
      ff_pos <= '0;
      fb_pos <= '0;
      ff_pw  <= PW_W'(nanc_pkg::POWER_EPS);
      fb_pw  <= PW_W'(nanc_pkg::POWER_EPS);
      fsel   <= 1'b0;
    end else begin
      case (state)
        nanc_pkg::ST_IDLE: fsel <= 1'b0;
        nanc_pkg::ST_PWADD: begin
          if (fsel) fb_pw <= fb_pw - PW_W'(prod);
          else ff_pw <= ff_pw - PW_W'(prod);
        end
        nanc_pkg::ST_PWFIN: begin
          if (fsel) fb_pw <= fb_pw + PW_W'(prod);
          else ff_pw <= ff_pw + PW_W'(prod);
        end
        nanc_pkg::ST_UPD: begin
          if (state_next != state) begin
            if (fsel) fb_pos <= (fb_pos == AW'(TAPS - 1)) ? '0 : fb_pos + 1'b1;
            else ff_pos <= (ff_pos == AW'(TAPS - 1)) ? '0 : ff_pos + 1'b1;
          end
        end
        nanc_pkg::ST_RES: fsel <= (state_next == nanc_pkg::ST_RDOLD);
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod <= mul_p;
    case (state)
      nanc_pkg::ST_IDLE: begin
        tgt    <= to_int(fb_sample);
        ref_x  <= nanc_pkg::RES_BITS'(to_int(ff_sample));
        raw_fb <= fb_sample;
        pass   <= !anc_enable;
      end
      nanc_pkg::ST_PWFIN: begin
        jptr <= pos_cur;
        acc  <= '0;
      end
      nanc_pkg::ST_FIR: begin
        if (cnt < CW'(TAPS)) jptr <= (jptr == AW'(TAPS - 1)) ? '0 : jptr + 1'b1;
        if (cnt >= CW'(2) && cnt <= CW'(TAPS + 1)) begin
          acc <= acc + nanc_pkg::PROD_BITS'(rnd(wide_t'(prod), 8));
        end
      end
      nanc_pkg::ST_ERR: begin
        y_reg <= err_y[nanc_pkg::W_BITS-1:0];
        eneg  <= (err_e < 0);
        mag   <= err_abs[31:0];
      end
      nanc_pkg::ST_DIVINIT: begin
        nreg <= {prod[nanc_pkg::NUM_BITS-1:0], 29'd0};
        rem  <= '0;
        q    <= '0;
        ovf  <= 1'b0;
      end
      nanc_pkg::ST_DIV: begin
        nreg <= {nreg[nanc_pkg::DIV_BITS-2:0], 1'b0};
        rem  <= ge ? r2 - den : r2;
        q    <= qn;
        // The quotient only grows, so once past the limit it stays clamped.
        ovf  <= ovf | (qn > nanc_pkg::GAIN_LIMIT);
      end
      nanc_pkg::ST_GSET: begin
        g    <= eneg ? -$signed(ovf ? nanc_pkg::GAIN_LIMIT : q)
                     : $signed(ovf ? nanc_pkg::GAIN_LIMIT : q);
        jptr <= pos_cur;
      end
      nanc_pkg::ST_UPD: begin
        if (!ph) begin
          lo_hold <= prod;
          if (tap < (CW-1)'(TAPS)) jptr <= (jptr == AW'(TAPS - 1)) ? '0 : jptr + 1'b1;
        end else begin
          xl <= x_rd;
          wl <= w_rd;
        end
      end
      nanc_pkg::ST_RES: begin
        rres  <= res_r[nanc_pkg::RES_BITS-1:0];
        ref_x <= res_r[nanc_pkg::RES_BITS-1:0];
        o_int <= res_s[nanc_pkg::INT_BITS-1:0];
      end
      nanc_pkg::ST_CFIN: o_int <= cor_r[nanc_pkg::INT_BITS-1:0];
      default: ;
    endcase
  end

  // Output register; a finished sample waits here while the next request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == nanc_pkg::ST_OUT && state_next == nanc_pkg::ST_IDLE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == nanc_pkg::ST_OUT && state_next == nanc_pkg::ST_IDLE) begin
      speaker_sample <= pass ? raw_fb : from_int(o_int);
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != nanc_pkg::ST_IDLE))
    else $error("accepted request did not start processing");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (ff_pos < AW'(TAPS - 1) || ff_pos == AW'(TAPS - 1)) &&
    (fb_pos < AW'(TAPS - 1) || fb_pos == AW'(TAPS - 1)))
    else $error("write position out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == nanc_pkg::ST_OUT && out_valid && out_stall) |=> (state == nanc_pkg::ST_OUT))
    else $error("result overwrote a pending output");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == nanc_pkg::ST_DIV) |-> (cnt < CW'(nanc_pkg::DIV_BITS)))
    else $error("divider ran past its last bit");

endmodule

// ----- sim/nlms_active_noise_canceller_test.sv -----
// Self-checking testbench for the NLMS noise canceller: directed table, then random phases.
`timescale 1ns / 1ps

module nlms_active_noise_canceller_test;

  localparam int TAPS = 512;
  localparam int WATCH_LIMIT = 40000;
  localparam int HOLD_CYCLES = 9000;
  localparam int RAND_ITEMS = 40;
  localparam logic [2:0] REG_UNUSED = 3'd5;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] ff_sample = '0;
  logic signed [23:0] fb_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] speaker_sample;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  nlms_active_noise_canceller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .ff_sample(ff_sample), .fb_sample(fb_sample),
    .out_valid(out_valid), .out_stall(out_stall), .speaker_sample(speaker_sample),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the register file and of both filters.
  logic cfg_enable;
  logic [2:0] cfg_mode;
  longint cfg_gain;
  longint cfg_ff_step, cfg_fb_step;
  longint tap_wgt[2][TAPS];
  longint tap_hist[2][TAPS];
  int tap_pos[2];

  logic [23:0] speaker_due[$];
  int errors = 0;
  int in_pct = 0;
  int stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_used = 1'b0;
  int hold_left = 0;
  int quiet = 0;

  typedef struct {
    logic is_cfg;
    logic [2:0] idx;
    logic [31:0] val;
    logic [23:0] ff;
    logic [23:0] fb;
    logic known;
    logic [23:0] want;
  } row_t;
  row_t plan[$];

  task automatic report(string what, logic [23:0] got, logic [23:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint round_shift(longint v, int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint unsigned adapt_gain(longint unsigned num, longint unsigned den);
    longint unsigned q, r, lim;
    lim = longint'(nanc_pkg::GAIN_LIMIT);
    q = num / den;
    r = num % den;
    if (q > lim) return lim;
    for (int i = 0; i < 29; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
      if (q > lim) return lim;
    end
    return q;
  endfunction

  // One NLMS step of filter f (0 feedforward, 1 feedback); returns the filter output.
  function automatic longint nlms_filter(int f, longint refv, longint target, longint step);
    int p, j;
    longint acc, y, e, g;
    longint unsigned pw, mag;
    p = tap_pos[f];
    tap_hist[f][p] = refv;
    acc = 0;
    for (int i = 0; i < TAPS; i++) begin
      j = (p + i) % TAPS;
      acc += round_shift(tap_wgt[f][i] * tap_hist[f][j], 8);
    end
    y = clamp(round_shift(acc, 22), 32);
    e = clamp(target - y, 32);
    pw = longint'(nanc_pkg::POWER_EPS);
    for (int i = 0; i < TAPS; i++) pw += tap_hist[f][i] * tap_hist[f][i];
    mag = (e < 0) ? -e : e;
    g = adapt_gain(step * mag, pw);
    if (e < 0) g = -g;
    for (int i = 0; i < TAPS; i++) begin
      j = (p + i) % TAPS;
      tap_wgt[f][i] = clamp(tap_wgt[f][i] + round_shift(g * tap_hist[f][j], 23), 32);
    end
    tap_pos[f] = (p + 1) % TAPS;
    return y;
  endfunction

  function automatic logic [23:0] predict_speaker(logic signed [23:0] ff, logic signed [23:0] fb);
    longint y, r;
    if (!cfg_enable) return fb;
    y = nlms_filter(0, longint'(ff), longint'(fb), cfg_ff_step);
    r = clamp(longint'(fb) - round_shift(y * cfg_gain, 12), 26);
    if (cfg_mode == nanc_pkg::MODE_FB_A || cfg_mode == nanc_pkg::MODE_FB_B) begin
      y = nlms_filter(1, r, longint'(fb), cfg_fb_step);
      r = r - round_shift(y * longint'(nanc_pkg::CORR_GAIN), 16);
    end
    return 24'(clamp(r, 24));
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      nanc_pkg::REG_ENABLE:  cfg_enable = val[0];
      nanc_pkg::REG_MODE:    cfg_mode = val[2:0];
      nanc_pkg::REG_GAIN:    cfg_gain = longint'($signed(val[15:0]));
      nanc_pkg::REG_FF_STEP: cfg_ff_step = val[19:0];
      nanc_pkg::REG_FB_STEP: cfg_fb_step = val[19:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Registers change only once the block has gone quiet.
  task automatic drain();
    while (speaker_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic send_request(logic [23:0] ff, logic [23:0] fb, logic known, logic [23:0] want);
    logic [23:0] due;
    while ($urandom_range(99) < in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ff_sample <= ff;
    fb_sample <= fb;
    do @(posedge clk); while (!(in_valid && !in_stall));
    due = predict_speaker(ff, fb);
    speaker_due.push_back(known ? want : due);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(255)) - 128);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [19:0] rand_step();
    case ($urandom_range(3))
      0: return 20'hFFFFF;
      1: return '0;
      default: return 20'($urandom_range(40000));
    endcase
  endfunction

  task automatic add_cfg(logic [2:0] idx, logic [31:0] val);
    plan.push_back('{1'b1, idx, val, '0, '0, 1'b0, '0});
  endtask

  task automatic add_item(logic [23:0] ff, logic [23:0] fb, logic known, logic [23:0] want);
    plan.push_back('{1'b0, '0, '0, ff, fb, known, want});
  endtask

  // Receiver: random stall, one long hold-off, and the comparison of each result.
  always @(posedge clk) begin
    if (out_valid && !out_stall && !rst) begin
      if (speaker_due.size() == 0) begin
        report("unexpected result", speaker_sample, '0);
      end else begin
        if (speaker_sample !== speaker_due[0])
          report("speaker_sample", speaker_sample, speaker_due[0]);
        void'(speaker_due.pop_front());
      end
    end
    if (hold_req && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCH_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    cfg_enable = nanc_pkg::RST_ENABLE;
    cfg_mode = nanc_pkg::RST_MODE;
    cfg_gain = nanc_pkg::RST_GAIN;
    cfg_ff_step = nanc_pkg::RST_FF_STEP;
    cfg_fb_step = nanc_pkg::RST_FB_STEP;
    tap_pos = '{0, 0};
    for (int f = 0; f < 2; f++)
      for (int i = 0; i < TAPS; i++) begin
        tap_wgt[f][i] = 0;
        tap_hist[f][i] = 0;
      end

    // With zero weights the first request returns its feedback sample.
    add_item(24'h7FFFFF, 24'h800000, 1'b1, 24'h800000);
    add_item(24'h800000, 24'h7FFFFF, 1'b0, '0);
    add_item(24'h000000, 24'h000000, 1'b0, '0);
    add_item(24'h7FFFFF, 24'h7FFFFF, 1'b0, '0);
    add_item(24'h800000, 24'h800000, 1'b0, '0);
    add_cfg(nanc_pkg::REG_GAIN, 32'h0000_7FFF);
    add_cfg(nanc_pkg::REG_FF_STEP, 32'h000F_FFFF);
    add_cfg(nanc_pkg::REG_FB_STEP, 32'h000F_FFFF);
    add_item(24'h7FFFFF, 24'h800000, 1'b0, '0);
    add_item(24'h800000, 24'h7FFFFF, 1'b0, '0);
    add_cfg(nanc_pkg::REG_GAIN, 32'h0000_8000);
    add_item(24'h7FFFFF, 24'h7FFFFF, 1'b0, '0);
    add_item(24'h123456, 24'hEDCBA9, 1'b0, '0);
    for (int m = 0; m < 8; m++) begin
      add_cfg(nanc_pkg::REG_MODE, m);
      add_item(24'h400000, 24'hC00001, 1'b0, '0);
    end
    add_cfg(REG_UNUSED, 32'hFFFF_FFFF);
    add_cfg(nanc_pkg::REG_ENABLE, 32'h0);
    add_item(24'h7FFFFF, 24'h800000, 1'b1, 24'h800000);
    add_item(24'h800000, 24'h7FFFFF, 1'b1, 24'h7FFFFF);
    add_cfg(nanc_pkg::REG_ENABLE, 32'h1);
    add_cfg(nanc_pkg::REG_FF_STEP, 32'h0);
    add_cfg(nanc_pkg::REG_FB_STEP, 32'h0);
    add_item(24'h000001, 24'hFFFFFF, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        in_valid <= 1'b0;
        drain();
        write_reg(plan[k].idx, plan[k].val);
      end else begin
        send_request(plan[k].ff, plan[k].fb, plan[k].known, plan[k].want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      in_valid <= 1'b0;
      drain();
      case (ph)
        0: begin in_pct = 0; stall_pct = 0; end
        1: begin in_pct = 54; stall_pct = 0; end
        2: begin in_pct = 0; stall_pct = 54; end
        default: begin in_pct = 11; stall_pct = 11; end
      endcase
      write_reg(nanc_pkg::REG_ENABLE, ($urandom_range(5) != 0));
      write_reg(nanc_pkg::REG_MODE, (ph == 0) ? nanc_pkg::MODE_FB_B : $urandom_range(7));
      write_reg(nanc_pkg::REG_GAIN, (ph == 1) ? 32'h0000_8000 : 32'($urandom_range(65535)));
      write_reg(nanc_pkg::REG_FF_STEP, rand_step());
      write_reg(nanc_pkg::REG_FB_STEP, rand_step());
      // Hold the output off while requests keep coming so the input backs up.
      if (ph == 0) hold_req <= 1'b1;
      for (int n = 0; n < RAND_ITEMS; n++) send_request(rand_sample(), rand_sample(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (speaker_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- nlms_active_noise_canceller.f -----
hdl/nanc_pkg.sv
hdl/nlms_active_noise_canceller.sv
sim/nlms_active_noise_canceller_test.sv
